>>> rtl/wavhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhc_pkg
// Shared types, header constants and the field table of the RIFF/WAVE
// header checker.
// ----------------------------------------------------------------------------
package wavhc_pkg;

    // Default greatest junk chunk size in bytes
    localparam int JUNK_MAX_DEF = 4096;

    // Reset value of the payload length limit
    localparam logic [30:0] MAX_LEN_RESET = 31'd79380000;

    // Last entry of the field table; the index stops here
    localparam logic [3:0] FIELD_LAST = 4'd15;

    // Expected format values
    localparam int FMT_SIZE    = 18;
    localparam int FMT_PCM     = 1;
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_RATE = 44100;
    localparam int BITS        = 16;
    localparam int BYTE_RATE   = SAMPLE_RATE * CHANNELS * BITS / 8;
    localparam int BLOCK_ALIGN = CHANNELS * BITS / 8;

    // Chunk tags, little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef enum logic [1:0] {
        ST_HDR  = 2'd0,
        ST_PAY  = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_RIFF_TAG    = 4'd1,
        ERR_FILE_SIZE   = 4'd2,
        ERR_WAVE_TAG    = 4'd3,
        ERR_FMT_TAG     = 4'd4,
        ERR_FMT_SIZE    = 4'd5,
        ERR_FORMAT      = 4'd6,
        ERR_CHANNELS    = 4'd7,
        ERR_RATE        = 4'd8,
        ERR_BYTE_RATE   = 4'd9,
        ERR_BLOCK_ALIGN = 4'd10,
        ERR_BITS        = 4'd11,
        ERR_JUNK_TAG    = 4'd12,
        ERR_JUNK_SIZE   = 4'd13,
        ERR_DATA_TAG    = 4'd14,
        ERR_DATA_LEN    = 4'd15
    } err_t;

    typedef enum logic [2:0] {
        KIND_EQ     = 3'd0,
        KIND_NONNEG = 3'd1,
        KIND_NONE   = 3'd2,
        KIND_JUNK   = 3'd3,
        KIND_LEN    = 3'd4
    } kind_t;

    typedef struct packed {
        logic        long_field;   // 4 bytes when set, else 2
        kind_t       kind;
        err_t        code;
        logic [31:0] expect_val;
    } field_desc_t;

    typedef struct packed {
        logic  long_field;
        kind_t kind;
        err_t  code;
        logic  ok;
    } field_chk_t;

    typedef struct packed {
        status_t     status;
        err_t        error_code;
        logic [7:0]  payload_byte;
        logic [30:0] data_length;
        logic        last;
    } result_t;

    // Header field table in file order
    function automatic field_desc_t field_desc(input logic [3:0] idx);
        field_desc_t d;
        unique case (idx)
            4'd0:  d = '{1'b1, KIND_EQ,     ERR_RIFF_TAG,    TAG_RIFF};
            4'd1:  d = '{1'b1, KIND_NONNEG, ERR_FILE_SIZE,   32'd0};
            4'd2:  d = '{1'b1, KIND_EQ,     ERR_WAVE_TAG,    TAG_WAVE};
            4'd3:  d = '{1'b1, KIND_EQ,     ERR_FMT_TAG,     TAG_FMT};
            4'd4:  d = '{1'b1, KIND_EQ,     ERR_FMT_SIZE,    32'(FMT_SIZE)};
            4'd5:  d = '{1'b0, KIND_EQ,     ERR_FORMAT,      32'(FMT_PCM)};
            4'd6:  d = '{1'b0, KIND_EQ,     ERR_CHANNELS,    32'(CHANNELS)};
            4'd7:  d = '{1'b1, KIND_EQ,     ERR_RATE,        32'(SAMPLE_RATE)};
            4'd8:  d = '{1'b1, KIND_EQ,     ERR_BYTE_RATE,   32'(BYTE_RATE)};
            4'd9:  d = '{1'b0, KIND_EQ,     ERR_BLOCK_ALIGN, 32'(BLOCK_ALIGN)};
            4'd10: d = '{1'b0, KIND_EQ,     ERR_BITS,        32'(BITS)};
            4'd11: d = '{1'b0, KIND_NONE,   ERR_NONE,        32'd0};
            4'd12: d = '{1'b1, KIND_EQ,     ERR_JUNK_TAG,    TAG_JUNK};
            4'd13: d = '{1'b1, KIND_JUNK,   ERR_JUNK_SIZE,   32'd0};
            4'd14: d = '{1'b1, KIND_EQ,     ERR_DATA_TAG,    TAG_DATA};
            4'd15: d = '{1'b1, KIND_LEN,    ERR_DATA_LEN,    32'd0};
        endcase
        return d;
    endfunction

endpackage

>>> rtl/wavhc_field_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhc_field_check
// Looks up one header field and tests its assembled value.
// ----------------------------------------------------------------------------
module wavhc_field_check #(
    parameter int JUNK_MAX = wavhc_pkg::JUNK_MAX_DEF
) (
    input  logic [3:0]             field_index,
    input  logic [31:0]            value,
    input  logic [30:0]            max_len,
    output wavhc_pkg::field_chk_t  chk
);

    wavhc_pkg::field_desc_t desc;
    logic                   neg;

    assign desc = wavhc_pkg::field_desc(field_index);
    assign neg  = value[31];

    // Test the value against the rule of its field
    always_comb begin
        chk.long_field = desc.long_field;
        chk.kind       = desc.kind;
        chk.code       = desc.code;
        unique case (desc.kind)
            wavhc_pkg::KIND_EQ:     chk.ok = (value == desc.expect_val);
            wavhc_pkg::KIND_NONNEG: chk.ok = !neg;
            wavhc_pkg::KIND_JUNK:   chk.ok = !neg && (value <= 32'(JUNK_MAX));
            wavhc_pkg::KIND_LEN:    chk.ok = !neg && (value[30:0] <= max_len);
            wavhc_pkg::KIND_NONE:   chk.ok = 1'b1;
            default:                chk.ok = 1'b1;
        endcase
    end

endmodule

>>> rtl/wavhc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhc_parser
// Parse state and per-byte result logic; state advances on each accepted item.
// ----------------------------------------------------------------------------
module wavhc_parser #(
    parameter int JUNK_MAX = wavhc_pkg::JUNK_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          byte_in,
    input  logic                start_req,
    input  logic [30:0]         max_len,
    output wavhc_pkg::result_t  res
);

    localparam int JW = $clog2(JUNK_MAX + 2);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_JUNK,
        PH_PAY,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t            phase_reg, phase_next, cur_phase;
    logic [3:0]        field_idx_reg, field_idx_next, cur_field_idx;
    logic [1:0]        offset_reg, offset_next, cur_offset;
    logic [31:0]       shift_reg, shift_next, cur_shift;
    logic [JW-1:0]     junk_reg, junk_next, cur_junk;
    logic [30:0]       pay_reg, pay_next, cur_pay;
    logic [30:0]       decl_reg, decl_next, cur_decl;
    wavhc_pkg::err_t   err_reg, err_next, cur_err;

    logic [31:0]            value;
    logic                   last_byte;
    wavhc_pkg::field_chk_t  chk;

    // Restart clears the parse state ahead of this item
    always_comb begin
        if (start_req) begin
            cur_phase     = PH_HDR;
            cur_field_idx = '0;
            cur_offset    = '0;
            cur_shift     = '0;
            cur_junk      = '0;
            cur_pay       = '0;
            cur_decl      = '0;
            cur_err       = wavhc_pkg::ERR_NONE;
        end else begin
            cur_phase     = phase_reg;
            cur_field_idx = field_idx_reg;
            cur_offset    = offset_reg;
            cur_shift     = shift_reg;
            cur_junk      = junk_reg;
            cur_pay       = pay_reg;
            cur_decl      = decl_reg;
            cur_err       = err_reg;
        end
    end

    // Merge the byte into the field, little-endian
    assign value = cur_shift | ({24'd0, byte_in} << {cur_offset, 3'b000});

    wavhc_field_check #(
        .JUNK_MAX(JUNK_MAX)
    ) u_check (
        .field_index(cur_field_idx),
        .value      (value),
        .max_len    (max_len),
        .chk        (chk)
    );

    assign last_byte = chk.long_field ? (cur_offset == 2'd3) : (cur_offset == 2'd1);

    // Next state and result for this item
    always_comb begin
        phase_next     = cur_phase;
        field_idx_next = cur_field_idx;
        offset_next    = cur_offset;
        shift_next     = cur_shift;
        junk_next      = cur_junk;
        pay_next       = cur_pay;
        decl_next      = cur_decl;
        err_next       = cur_err;

        res.status       = wavhc_pkg::ST_HDR;
        res.error_code   = wavhc_pkg::ERR_NONE;
        res.payload_byte = '0;
        res.last         = 1'b0;

        unique case (cur_phase)
            PH_HDR: begin
                if (!last_byte) begin
                    shift_next  = value;
                    offset_next = cur_offset + 2'd1;
                end else begin
                    shift_next  = '0;
                    offset_next = '0;
                    if (!chk.ok) begin
                        err_next       = chk.code;
                        phase_next     = PH_ERR;
                        res.status     = wavhc_pkg::ST_ERR;
                        res.error_code = chk.code;
                    end else begin
                        if (chk.kind == wavhc_pkg::KIND_JUNK) begin
                            junk_next = value[JW-1:0];
                            if (value != 32'd0) begin
                                phase_next = PH_JUNK;
                            end
                        end else if (chk.kind == wavhc_pkg::KIND_LEN) begin
                            decl_next  = value[30:0];
                            pay_next   = value[30:0];
                            phase_next = (value[30:0] != 31'd0) ? PH_PAY : PH_DONE;
                        end
                        if (cur_field_idx != wavhc_pkg::FIELD_LAST) begin
                            field_idx_next = cur_field_idx + 4'd1;
                        end
                    end
                end
            end
            PH_JUNK: begin
                // skip junk bytes, then back to the header
                junk_next = cur_junk - JW'(1);
                if (cur_junk == JW'(1)) begin
                    phase_next = PH_HDR;
                end
            end
            PH_PAY: begin
                res.status       = wavhc_pkg::ST_PAY;
                res.payload_byte = byte_in;
                pay_next         = cur_pay - 31'd1;
                if (cur_pay == 31'd1) begin
                    res.last   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                res.status = wavhc_pkg::ST_DONE;
            end
            PH_ERR: begin
                res.status     = wavhc_pkg::ST_ERR;
                res.error_code = cur_err;
            end
            default: begin
                res.status     = wavhc_pkg::ST_ERR;
                res.error_code = cur_err;
            end
        endcase

        res.data_length = decl_next;
    end

    // Advance parse state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR;
            field_idx_reg <= '0;
            offset_reg    <= '0;
            shift_reg     <= '0;
            junk_reg      <= '0;
            pay_reg       <= '0;
            decl_reg      <= '0;
            err_reg       <= wavhc_pkg::ERR_NONE;
        end else if (accept) begin
            phase_reg     <= phase_next;
            field_idx_reg <= field_idx_next;
            offset_reg    <= offset_next;
            shift_reg     <= shift_next;
            junk_reg      <= junk_next;
            pay_reg       <= pay_next;
            decl_reg      <= decl_next;
            err_reg       <= err_next;
        end
    end

endmodule

>>> rtl/wavhc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhc_out_reg
// Result register; takes a new item whenever empty or being drained.
// ----------------------------------------------------------------------------
module wavhc_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  wavhc_pkg::result_t  in_res,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wavhc_pkg::result_t  out_res
);

    logic                valid_reg;
    wavhc_pkg::result_t  res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Load result on accept
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

endmodule

>>> rtl/wav_header_checker_core.sv
`timescale 1ns / 1ps
// An accepted item's result is registered and is on m_tvalid the next cycle.
// Throughput: one item per cycle unless m_tready stalls; set by the single
//   result register, taking a new item in the same cycle the last drains.
// Reset: aresetn low clears the parse state (waiting for a RIFF tag), empties
//   the result register and sets the payload length limit to 79380000.
// ----------------------------------------------------------------------------
// wav_header_checker_core
// Byte-serial RIFF/WAVE header checker with payload pass-through.
// ----------------------------------------------------------------------------
module wav_header_checker_core #(
    parameter int JUNK_MAX = wavhc_pkg::JUNK_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    input  logic        s_tuser,     // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [3:0] error_code, [11:4] payload_byte,
                                     // [42:12] data_length, [47:43] zero
    output logic [1:0]  m_tuser,     // [1:0] status
    output logic        m_tlast,     // last_payload
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data  // max_audio_length
);

    logic                accept;
    logic [30:0]         max_len_reg;
    wavhc_pkg::result_t  res_new;
    wavhc_pkg::result_t  res_out;

    assign accept = s_tvalid && s_tready;

    // Hold the payload length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= wavhc_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    wavhc_parser #(
        .JUNK_MAX(JUNK_MAX)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .byte_in  (s_tdata),
        .start_req(s_tuser),
        .max_len  (max_len_reg),
        .res      (res_new)
    );

    wavhc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_res   (res_new),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res_out)
    );

    // Pack the result item
    assign m_tdata = {5'd0, res_out.data_length, res_out.payload_byte, res_out.error_code};
    assign m_tuser = res_out.status;
    assign m_tlast = res_out.last;

`ifndef ASSERT_OFF
    // Last marker only on a payload byte
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == wavhc_pkg::ST_PAY)
        else $error("last marker outside payload");

    // Error code nonzero exactly when status reports an error
    a_code_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == wavhc_pkg::ST_ERR) == (m_tdata[3:0] != 4'd0)))
        else $error("error code does not match status");

    // Payload byte is zero outside the payload
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != wavhc_pkg::ST_PAY |-> m_tdata[11:4] == 8'd0)
        else $error("payload byte set outside payload");

    // An empty result register always takes an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the RIFF/WAVE header checker. Files are streamed into the
// block one byte per item: directed files hit every header check, both size
// limits at their edges, restarts in each parse phase and a long output
// stall. An in-bench parser predicts each result, and every output item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PERIOD     = 20;
    localparam int JUNK_LIMIT = wavhc_pkg::JUNK_MAX_DEF;
    localparam int TIMEOUT_NS = 5_000_000;

    // Parse phases of the in-bench parser
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_AUDIO,
        PH_FINISHED,
        PH_FAILED
    } parse_phase_t;

    // One header field: size in bytes, kind of check, error code, wanted value
    typedef struct packed {
        logic [2:0]       nbytes;
        wavhc_pkg::kind_t kind;
        wavhc_pkg::err_t  code;
        logic [31:0]      want;
    } hdr_rule_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [30:0] cfg_wr_data = '0;

    // Parser state of the prediction
    parse_phase_t    ph;
    logic [3:0]      fidx;
    logic [2:0]      foff;
    logic [31:0]     fval;
    logic [31:0]     junk_left;
    logic [30:0]     audio_left;
    logic [30:0]     decl_len;
    wavhc_pkg::err_t err_hold;
    logic [30:0]     limit_len;

    wavhc_pkg::result_t results_due[$];
    logic [31:0]        hdr_vals[16];
    int                 results_seen = 0;
    int                 mismatches   = 0;
    int                 hold_cycles  = 0;
    bit                 src_gaps     = 1'b1;

    wav_header_checker_core #(
        .JUNK_MAX(JUNK_LIMIT)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Header layout in file order
    function automatic hdr_rule_t field_rule(input logic [3:0] idx);
        hdr_rule_t r;
        unique case (idx)
            4'd0:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_RIFF_TAG,
                           wavhc_pkg::TAG_RIFF};
            4'd1:    r = '{3'd4, wavhc_pkg::KIND_NONNEG, wavhc_pkg::ERR_FILE_SIZE, 32'd0};
            4'd2:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_WAVE_TAG,
                           wavhc_pkg::TAG_WAVE};
            4'd3:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_FMT_TAG,
                           wavhc_pkg::TAG_FMT};
            4'd4:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_FMT_SIZE,
                           32'(wavhc_pkg::FMT_SIZE)};
            4'd5:    r = '{3'd2, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_FORMAT,
                           32'(wavhc_pkg::FMT_PCM)};
            4'd6:    r = '{3'd2, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_CHANNELS,
                           32'(wavhc_pkg::CHANNELS)};
            4'd7:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_RATE,
                           32'(wavhc_pkg::SAMPLE_RATE)};
            4'd8:    r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_BYTE_RATE,
                           32'(wavhc_pkg::BYTE_RATE)};
            4'd9:    r = '{3'd2, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_BLOCK_ALIGN,
                           32'(wavhc_pkg::BLOCK_ALIGN)};
            4'd10:   r = '{3'd2, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_BITS,
                           32'(wavhc_pkg::BITS)};
            4'd11:   r = '{3'd2, wavhc_pkg::KIND_NONE, wavhc_pkg::ERR_NONE, 32'd0};
            4'd12:   r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_JUNK_TAG,
                           wavhc_pkg::TAG_JUNK};
            4'd13:   r = '{3'd4, wavhc_pkg::KIND_JUNK, wavhc_pkg::ERR_JUNK_SIZE, 32'd0};
            4'd14:   r = '{3'd4, wavhc_pkg::KIND_EQ, wavhc_pkg::ERR_DATA_TAG,
                           wavhc_pkg::TAG_DATA};
            default: r = '{3'd4, wavhc_pkg::KIND_LEN, wavhc_pkg::ERR_DATA_LEN, 32'd0};
        endcase
        return r;
    endfunction

    // Clear parse state and the error latch
    function automatic void restart_parser();
        ph         = PH_HEADER;
        fidx       = '0;
        foff       = '0;
        fval       = '0;
        junk_left  = '0;
        audio_left = '0;
        decl_len   = '0;
        err_hold   = wavhc_pkg::ERR_NONE;
    endfunction

    // Advance the parser by one byte and return the result it causes
    function automatic wavhc_pkg::result_t predict_byte(input logic [7:0] b,
                                                        input logic start);
        wavhc_pkg::result_t r;
        hdr_rule_t          rule;
        logic [31:0]        v;
        bit                 ok;
        r = '{wavhc_pkg::ST_HDR, wavhc_pkg::ERR_NONE, 8'd0, 31'd0, 1'b0};
        if (start) begin
            restart_parser();
        end
        unique case (ph)
            PH_HEADER: begin
                rule = field_rule(fidx);
                fval = fval | (32'(b) << (8 * foff));
                foff = foff + 3'd1;
                if (foff == rule.nbytes) begin
                    v    = fval;
                    foff = '0;
                    fval = '0;
                    unique case (rule.kind)
                        wavhc_pkg::KIND_EQ:     ok = (v == rule.want);
                        wavhc_pkg::KIND_NONNEG: ok = !v[31];
                        wavhc_pkg::KIND_JUNK:   ok = !v[31] && (v <= 32'(JUNK_LIMIT));
                        wavhc_pkg::KIND_LEN:    ok = !v[31] && (v[30:0] <= limit_len);
                        default:                ok = 1'b1;
                    endcase
                    if (!ok) begin
                        err_hold     = rule.code;
                        ph           = PH_FAILED;
                        r.status     = wavhc_pkg::ST_ERR;
                        r.error_code = rule.code;
                    end else begin
                        if (rule.kind == wavhc_pkg::KIND_JUNK) begin
                            junk_left = v;
                            if (v != 0) ph = PH_SKIP;
                        end else if (rule.kind == wavhc_pkg::KIND_LEN) begin
                            decl_len   = v[30:0];
                            audio_left = v[30:0];
                            ph         = (v != 0) ? PH_AUDIO : PH_FINISHED;
                        end
                        if (fidx != wavhc_pkg::FIELD_LAST) fidx = fidx + 4'd1;
                    end
                end
            end
            PH_SKIP: begin
                if (junk_left != 0) junk_left = junk_left - 1;
                if (junk_left == 0) ph = PH_HEADER;
            end
            PH_AUDIO: begin
                r.status       = wavhc_pkg::ST_PAY;
                r.payload_byte = b;
                if (audio_left != 0) audio_left = audio_left - 31'd1;
                if (audio_left == 0) begin
                    r.last = 1'b1;
                    ph     = PH_FINISHED;
                end
            end
            PH_FINISHED: r.status = wavhc_pkg::ST_DONE;
            default: begin
                r.status     = wavhc_pkg::ST_ERR;
                r.error_code = err_hold;
            end
        endcase
        r.data_length = decl_len;
        return r;
    endfunction

    // A value that fails the check of the given field
    function automatic logic [31:0] bad_value(input logic [3:0] idx);
        hdr_rule_t r;
        int        pos;
        r   = field_rule(idx);
        pos = $urandom_range(0, int'(r.nbytes) - 1);
        unique case (r.kind)
            wavhc_pkg::KIND_EQ:
                return r.want ^ (32'($urandom_range(1, 255)) << (8 * pos));
            wavhc_pkg::KIND_NONNEG:
                return {1'b1, 31'($urandom)};
            wavhc_pkg::KIND_JUNK:
                return $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                                            : 32'(JUNK_LIMIT + 1 + $urandom_range(0, 50));
            wavhc_pkg::KIND_LEN:
                return (limit_len == '1 || $urandom_range(0, 1)) ? {1'b1, 31'($urandom)}
                       : {1'b0, limit_len} + 32'($urandom_range(1, 4));
            default:
                return 32'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d %s: got 0x%0h, want 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic start);
        int gap;
        gap = src_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(predict_byte(b, start));
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [30:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_len    = value;
    endtask

    // Fill the header with passing values and the given sizes
    task automatic set_header(input logic [31:0] file_size, input logic [31:0] junk_size,
                              input logic [31:0] data_len);
        hdr_rule_t r;
        for (int i = 0; i < 16; i++) begin
            r           = field_rule(4'(i));
            hdr_vals[i] = r.want;
        end
        hdr_vals[1]  = file_size;
        hdr_vals[11] = 32'($urandom);
        hdr_vals[13] = junk_size;
        hdr_vals[15] = data_len;
    endtask

    // Stream the first nfields header fields, junk before the data tag,
    // then extra_n random bytes (payload, tail or next-field bytes)
    task automatic send_wav(input int nfields, input int junk_n, input int extra_n,
                            input bit with_start);
        hdr_rule_t r;
        bit        first;
        first = with_start;
        for (int i = 0; i < nfields && i < 16; i++) begin
            r = field_rule(4'(i));
            if (i == 14) begin
                for (int j = 0; j < junk_n; j++) send_item(8'($urandom), 1'b0);
            end
            for (int j = 0; j < int'(r.nbytes); j++) begin
                send_item(hdr_vals[i][8 * j +: 8], first);
                first = 1'b0;
            end
        end
        for (int j = 0; j < extra_n; j++) send_item(8'($urandom), 1'b0);
    endtask

    // No start on the first file; length limit still at its reset value
    task automatic test_reset_defaults();
        set_header(32'd0, 32'd0, {1'b0, wavhc_pkg::MAX_LEN_RESET});
        send_wav(16, 0, 3, 1'b0);
        set_header(32'h7FFF_FFFF, 32'd0, {1'b0, wavhc_pkg::MAX_LEN_RESET} + 32'd1);
        send_wav(16, 0, 2, 1'b1);
    endtask

    // Zero length under a zero limit, then the largest length and limit
    task automatic test_length_limits();
        write_limit(31'd0);
        set_header(32'd36, 32'd0, 32'd0);
        send_wav(16, 0, 2, 1'b1);
        write_limit(31'h7FFF_FFFF);
        set_header(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        send_wav(16, 0, 3, 1'b1);
    endtask

    // Junk size at the maximum; the next file restarts inside the junk
    task automatic test_junk_sizes();
        set_header(32'd36, 32'(JUNK_LIMIT), 32'd4);
        send_wav(14, 0, 5, 1'b1);
    endtask

    // Fail every check before the data length once, junk size just past its maximum
    task automatic test_each_check();
        for (int f = 0; f < 15; f++) begin
            if (f != 11) begin
                set_header(32'd36, 32'd0, 32'd3);
                hdr_vals[f] = (f == 13) ? 32'(JUNK_LIMIT + 1) : bad_value(4'(f));
                send_wav(f + 1, 0, 1, 1'b1);
            end
        end
    endtask

    // Restart inside a field
    task automatic test_restart();
        set_header(32'd36, 32'd0, 32'd4);
        send_wav(2, 0, 2, 1'b1);
    endtask

    // Hold the output off for a long stretch while bytes keep coming;
    // payload exactly at the limit, junk skipped, complete tail
    task automatic test_backpressure();
        write_limit(31'd5);
        src_gaps    = 1'b0;
        hold_cycles = 300;
        set_header(32'd64, 32'd3, 32'd5);
        send_wav(16, 3, 8, 1'b1);
        src_gaps    = 1'b1;
    endtask

    // Result sink: random stall per item, plus an optional long hold
    initial begin : sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each output item with the oldest prediction
    always @(posedge aclk) begin : check_results
        wavhc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_tdata[42:0]), 32'd0);
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[3:0] !== want.error_code)
                    report_mismatch("error_code", 32'(m_tdata[3:0]), 32'(want.error_code));
                if (m_tdata[11:4] !== want.payload_byte)
                    report_mismatch("payload_byte", 32'(m_tdata[11:4]),
                                    32'(want.payload_byte));
                if (m_tdata[42:12] !== want.data_length)
                    report_mismatch("data_length", 32'(m_tdata[42:12]),
                                    32'(want.data_length));
                if (m_tlast !== want.last)
                    report_mismatch("last_payload", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        restart_parser();
        limit_len = wavhc_pkg::MAX_LEN_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_length_limits();
        test_junk_sizes();
        test_each_check();
        test_restart();
        test_backpressure();

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wavhc_pkg.sv
rtl/wavhc_field_check.sv
rtl/wavhc_parser.sv
rtl/wavhc_out_reg.sv
rtl/wav_header_checker_core.sv
sim/tb_top.sv
